// ----- hw/rtl/plwm_pkg.sv -----
// shared types and constants for the piecewise-linear step/position map
// no dependencies
package plwm_pkg;

  localparam int SEGMENTS  = 16;
  localparam int SEG_IDX_W = $clog2(SEGMENTS);
  localparam int K_W       = $clog2(SEGMENTS + 1);

  localparam int LEN_W = 24;
  localparam int INC_W = 24;
  localparam int DVD_W = 48;
  localparam int QUO_W = DVD_W;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_S2P   = 2'd1;
  localparam logic [1:0] OP_P2S   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         entry_index;
    logic [INC_W-1:0]   entry_increment;
    logic signed [23:0] step_count_in;
    logic signed [31:0] from_position;
    logic signed [31:0] to_position;
  } plwm_in_t;

  typedef struct packed {
    logic signed [31:0] axis_position;
    logic [31:0]        steps_needed;
    logic               overflow;
  } plwm_out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [INC_W-1:0] divisor;
  } plwm_div_req_t;

endpackage

// ----- hw/rtl/piecewise_linear_step_position_map.sv -----
// piecewise-linear step/position map: sequencer, increment table and output beat
// depends on plwm_pkg and plwm_div
// flow: write and no-op beats go straight to the finish state; a conversion
// runs one serial division per table segment visited, and a step-to-position
// conversion then adds a shift-add remainder multiply if a remainder is left;
// one beat at a time, in_stall holds new beats until the result beat is taken
// reset: synchronous active-low, segment length returns to 65536, the table is
// left as is (undefined until written)
module piecewise_linear_step_position_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plwm_pkg::plwm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plwm_pkg::plwm_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [23:0]         cfg_wr_data
);
  import plwm_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;  // pick next segment, launch division
  localparam logic [2:0] S_DIV  = 3'd2;  // wait for quotient
  localparam logic [2:0] S_REM  = 3'd3;  // remainder of a step conversion
  localparam logic [2:0] S_MUL  = 3'd4;  // shift-add remainder times increment
  localparam logic [2:0] S_FIN  = 3'd5;  // saturate, sign, load output beat

  logic [2:0] state_r, state_nxt;

  // configuration and table
  logic [LEN_W-1:0] seg_len_r;
  logic [INC_W-1:0] inc_table_r [SEGMENTS];

  // per-beat working registers
  logic [1:0]       op_r;
  logic             neg_r;
  logic [31:0]      target_r;   // step magnitude with 8 fraction bits
  logic [31:0]      lo_end_r, hi_end_r;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [32:0]      s0_r, s0_nxt;     // start of segment k
  logic [31:0]      acc_r, acc_nxt;   // accumulated whole-segment steps
  logic [47:0]      pos_r, pos_nxt;
  logic [51:0]      total_r, total_nxt;
  logic [55:0]      prod_r, prod_nxt;
  logic [55:0]      mcand_r, mcand_nxt;
  logic [INC_W-1:0] mpl_r, mpl_nxt;
  logic [4:0]       mul_cnt_r, mul_cnt_nxt;

  logic      out_valid_r;
  plwm_out_t out_data_r;

  logic            accept;
  logic            last_seg;
  logic [SEG_IDX_W-1:0] kc;
  logic [INC_W-1:0] inc_k;
  logic [32:0]     s1, lo, hi;
  logic [31:0]     span;
  logic [48:0]     sum;
  logic [31:0]     rem;
  logic [40:0]     frac_pos;
  logic [6:0]      widx_ext;
  logic [SEG_IDX_W-1:0] widx;
  logic [23:0]     step_mag;
  logic [31:0]     mag_from, mag_to;
  logic [31:0]     pos_sat;
  logic            pos_ovf, tot_ovf;
  plwm_out_t       fin_data;

  plwm_div_req_t div_req;
  logic          div_done;
  logic [QUO_W-1:0] div_q;

  plwm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_q)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  // table read at segment k, clamped past the end; a zero entry acts as 1
  assign kc    = (k_r >= K_W'(SEGMENTS)) ? SEG_IDX_W'(SEGMENTS - 1) : k_r[SEG_IDX_W-1:0];
  assign inc_k = (inc_table_r[kc] == '0) ? INC_W'(1) : inc_table_r[kc];

  // write index clamp
  assign widx_ext = 7'(in_data.entry_index);
  assign widx     = (widx_ext >= 7'(SEGMENTS)) ? SEG_IDX_W'(SEGMENTS - 1)
                                               : widx_ext[SEG_IDX_W-1:0];

  // input magnitudes
  assign step_mag = in_data.step_count_in[23] ? 24'(-in_data.step_count_in)
                                              : in_data.step_count_in;
  assign mag_from = in_data.from_position[31] ? 32'(-in_data.from_position)
                                              : in_data.from_position;
  assign mag_to   = in_data.to_position[31] ? 32'(-in_data.to_position)
                                            : in_data.to_position;

  // clipped span of segment k, the last one runs open-ended
  assign last_seg = (k_r == K_W'(SEGMENTS - 1));
  assign s1   = s0_r + 33'(seg_len_r);
  assign lo   = ({1'b0, lo_end_r} > s0_r) ? {1'b0, lo_end_r} : s0_r;
  assign hi   = (last_seg || ({1'b0, hi_end_r} < s1)) ? {1'b0, hi_end_r} : s1;
  assign span = 32'(hi - lo);

  assign sum      = 49'(acc_r) + 49'(div_q);
  assign rem      = target_r - acc_r;
  assign frac_pos = 41'((57'(prod_r) + 57'd32768) >> 16);

  // final saturation and sign
  always_comb begin
    pos_ovf = pos_r > 48'h7FFF_FFFF;
    pos_sat = pos_ovf ? 32'h7FFF_FFFF : pos_r[31:0];
    tot_ovf = total_r > 52'hFFFF_FFFF;
    fin_data = '0;
    unique case (op_r)
      OP_S2P: begin
        fin_data.axis_position = neg_r ? 32'(-pos_sat) : pos_sat;
        fin_data.overflow      = pos_ovf;
      end
      OP_P2S: begin
        fin_data.steps_needed = tot_ovf ? 32'hFFFF_FFFF : total_r[31:0];
        fin_data.overflow     = tot_ovf;
      end
      default: fin_data = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    s0_nxt      = s0_r;
    acc_nxt     = acc_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    prod_nxt    = prod_r;
    mcand_nxt   = mcand_r;
    mpl_nxt     = mpl_r;
    mul_cnt_nxt = mul_cnt_r;
    div_req     = '0;
    div_req.divisor = inc_k;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt     = '0;
          s0_nxt    = '0;
          acc_nxt   = '0;
          pos_nxt   = '0;
          total_nxt = '0;
          state_nxt = (in_data.opcode == OP_S2P || in_data.opcode == OP_P2S) ? S_SEG
                                                                             : S_FIN;
        end
      end
      S_SEG: begin
        if (op_r == OP_S2P) begin
          if (k_r == K_W'(SEGMENTS)) begin
            state_nxt = S_REM;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'({seg_len_r, 16'h0});
            state_nxt        = S_DIV;
          end
        end else if (hi > lo) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'({span, 16'h0});
          state_nxt        = S_DIV;
        end else if (last_seg) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt  = k_r + 1'b1;
          s0_nxt = s1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_r == OP_S2P) begin
            if (sum >= 49'(target_r)) begin
              state_nxt = S_REM;
            end else begin
              acc_nxt   = sum[31:0];
              pos_nxt   = pos_r + 48'(seg_len_r);
              k_nxt     = k_r + 1'b1;
              state_nxt = S_SEG;
            end
          end else begin
            total_nxt = total_r + 52'(div_q);
            if (last_seg) begin
              state_nxt = S_FIN;
            end else begin
              k_nxt     = k_r + 1'b1;
              s0_nxt    = s1;
              state_nxt = S_SEG;
            end
          end
        end
      end
      S_REM: begin
        if (rem == '0) begin
          state_nxt = S_FIN;
        end else begin
          prod_nxt    = '0;
          mcand_nxt   = 56'(rem);
          mpl_nxt     = inc_k;
          mul_cnt_nxt = 5'(INC_W);
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_cnt_r == '0) begin
          pos_nxt   = pos_r + 48'(frac_pos);
          state_nxt = S_FIN;
        end else begin
          if (mpl_r[0]) prod_nxt = prod_r + mcand_r;
          mcand_nxt   = {mcand_r[54:0], 1'b0};
          mpl_nxt     = {1'b0, mpl_r[INC_W-1:1]};
          mul_cnt_nxt = mul_cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seg_len_r   <= LEN_W'(65536);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) seg_len_r <= cfg_wr_data;
    end
    if (state_r == S_FIN) out_data_r <= fin_data;
    if (accept) begin
      op_r     <= in_data.opcode;
      neg_r    <= in_data.step_count_in[23];
      target_r <= {step_mag, 8'h0};
      lo_end_r <= (mag_from < mag_to) ? mag_from : mag_to;
      hi_end_r <= (mag_from < mag_to) ? mag_to : mag_from;
      if (in_data.opcode == OP_WRITE) inc_table_r[widx] <= in_data.entry_increment;
    end
    k_r       <= k_nxt;
    s0_r      <= s0_nxt;
    acc_r     <= acc_nxt;
    pos_r     <= pos_nxt;
    total_r   <= total_nxt;
    prod_r    <= prod_nxt;
    mcand_r   <= mcand_nxt;
    mpl_r     <= mpl_nxt;
    mul_cnt_r <= mul_cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a quotient only arrives while the sequencer waits for one
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the wait state");

  // an accepted beat always leaves idle on the next cycle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted beat did not start the sequencer");

  // a result beat is loaded in the cycle after the finish state
  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_valid_r)
    else $error("finish state did not load the result beat");

  // the step walk never goes past one slot beyond the table
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> k_r <= K_W'(SEGMENTS))
    else $error("segment counter out of range");

endmodule

// ----- hw/rtl/plwm_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on plwm_pkg
module plwm_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  plwm_pkg::plwm_div_req_t req,
  output logic                   done,
  output logic [plwm_pkg::QUO_W-1:0] quotient
);
  import plwm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [INC_W-1:0] rem_r, rem_nxt;
  logic [INC_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [INC_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    ge       = trial >= {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? INC_W'(trial - {1'b0, dsr_r}) : trial[INC_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (req.start) dsr_r <= req.divisor;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
